[hdl/stl_pkg.sv]
`default_nettype none

package stl_pkg;

    localparam int MAX_IDENT_LEN  = 32;
    localparam int POSITION_WIDTH = 16;
    localparam int IDENT_LEN_W    = 6;
    localparam int TAB_MASK       = 7;

    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_VTAB    = 8'h0b;
    localparam logic [7:0] CH_FFEED   = 8'h0c;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_DOT     = 8'h2e;

    typedef enum logic [2:0] {
        KIND_PUNCT    = 3'd0,
        KIND_ID_CHAR  = 3'd1,
        KIND_ID_END   = 3'd2,
        KIND_CON_CHAR = 3'd3,
        KIND_CON_END  = 3'd4,
        KIND_EOF      = 3'd5,
        KIND_BAD_CHAR = 3'd6,
        KIND_BAD_CON  = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic [7:0]                  character;
        logic [POSITION_WIDTH-1:0]   line;
        logic [POSITION_WIDTH-1:0]   column;
        logic                        last;
    } result_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_id_start(input logic [7:0] b);
        return is_letter(b) || b == 8'h24 || b == 8'h5f;
    endfunction

    function automatic logic is_id_char(input logic [7:0] b);
        return is_id_start(b) || is_digit(b);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return b == 8'h25 || b == 8'h26 || b == 8'h28 || b == 8'h29 || b == 8'h2a ||
               b == 8'h2b || b == 8'h2c || b == 8'h2d || b == 8'h3b || b == 8'h3d ||
               b == 8'h7c;
    endfunction

endpackage

`default_nettype wire

[hdl/script_token_lexer.sv]
`default_nettype none

// channel | beat fields                      | handshake
// --------+----------------------------------+----------------------
// input   | byte_in, end_of_input            | in_valid / in_ready
// output  | kind, character, line, column,   | out_valid / out_ready
//         | last                             |
//
// one input beat per cycle while in_ready is high; a beat is classified in its accept cycle and its
// zero, one or two results enter a four-entry queue, visible the next cycle
// the queue drains one result per cycle while out_ready is high, so a run of
// two-result beats fills the queue and in_ready drops between accepted beats
// in_ready is high while the queue has room for two results, independent of
// out_ready; rst_n clears scan mode, counters and queue pointers (line 0, col 0)

module script_token_lexer
    import stl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_in,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [7:0]       character,
    output logic [15:0]      line,
    output logic [15:0]      column,
    output logic             last
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_CONST = 3'd2,
        MODE_SLASH = 3'd3,
        MODE_LINEC = 3'd4,
        MODE_BLOCK = 3'd5,
        MODE_STAR  = 3'd6
    } mode_t;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    // scan state
    mode_t                     mode_reg,  mode_next;
    logic [IDENT_LEN_W-1:0]    len_reg,   len_next;
    logic [1:0]                dots_reg,  dots_next;
    logic                      digit_reg, digit_next;
    logic [POSITION_WIDTH-1:0] line_reg,  line_next;
    logic [POSITION_WIDTH-1:0] col_reg,   col_next;

    // result queue
    result_t                   queue_reg [4];
    logic [1:0]                wr_ptr_reg, wr_ptr_next;
    logic [1:0]                rd_ptr_reg, rd_ptr_next;
    logic [2:0]                count_reg,  count_next;

    logic                      in_fire;
    logic                      out_fire;
    logic [POSITION_WIDTH-1:0] col_inc;

    // token-closing result (uses the column before this byte)
    logic                      cls_valid;
    kind_t                     cls_kind;
    logic [7:0]                cls_char;
    logic                      closing;
    logic                      starting;

    // result of the byte itself, or end of file
    logic                      tok_valid;
    kind_t                     tok_kind;
    logic [7:0]                tok_char;
    logic [POSITION_WIDTH-1:0] tok_col;

    result_t                   ent_a;
    result_t                   ent_b;
    logic [1:0]                n_wr;

    assign in_ready  = count_reg <= 3'd2;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = count_reg != 3'd0;
    assign out_fire  = out_valid && out_ready;

    // column advance, saturating
    assign col_inc = (col_reg == POS_MAX) ? col_reg : col_reg + 1'b1;

    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        dots_next  = dots_reg;
        digit_next = digit_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        closing    = 1'b0;
        starting   = 1'b0;
        cls_valid  = 1'b0;
        cls_kind   = KIND_PUNCT;
        cls_char   = '0;
        tok_valid  = 1'b0;
        tok_kind   = KIND_PUNCT;
        tok_char   = '0;
        tok_col    = col_inc;

        if (in_fire)
        begin
            if (end_of_input)
            begin
                // close what is open, then report end of file in place
                closing   = 1'b1;
                tok_valid = 1'b1;
                tok_kind  = KIND_EOF;
                tok_col   = col_reg;
            end
            else
            begin
                case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (is_id_char(byte_in))
                        begin
                            col_next = col_inc;
                            if (len_reg < IDENT_LEN_W'(MAX_IDENT_LEN))
                            begin
                                len_next  = len_reg + 1'b1;
                                tok_valid = 1'b1;
                                tok_kind  = KIND_ID_CHAR;
                                tok_char  = byte_in;
                            end
                        end
                        else
                        begin
                            closing  = 1'b1;
                            starting = 1'b1;
                        end
                    end
                    MODE_CONST:
                    begin
                        if (is_digit(byte_in) || byte_in == CH_DOT)
                        begin
                            col_next = col_inc;
                            if (byte_in == CH_DOT)
                            begin
                                if (dots_reg != 2'd2)
                                    dots_next = dots_reg + 1'b1;
                            end
                            else
                            begin
                                digit_next = 1'b1;
                            end
                            tok_valid = 1'b1;
                            tok_kind  = KIND_CON_CHAR;
                            tok_char  = byte_in;
                        end
                        else
                        begin
                            closing  = 1'b1;
                            starting = 1'b1;
                        end
                    end
                    MODE_SLASH:
                    begin
                        if (byte_in == CH_SLASH)
                        begin
                            col_next  = col_inc;
                            mode_next = MODE_LINEC;
                        end
                        else if (byte_in == CH_STAR)
                        begin
                            col_next  = col_inc;
                            mode_next = MODE_BLOCK;
                        end
                        else
                        begin
                            closing  = 1'b1;
                            starting = 1'b1;
                        end
                    end
                    MODE_LINEC:
                    begin
                        // newlines in comments move the column only
                        col_next = col_inc;
                        if (byte_in == CH_NEWLINE)
                            mode_next = MODE_IDLE;
                    end
                    MODE_BLOCK:
                    begin
                        col_next = col_inc;
                        if (byte_in == CH_STAR)
                            mode_next = MODE_STAR;
                    end
                    MODE_STAR:
                    begin
                        col_next = col_inc;
                        if (byte_in == CH_SLASH)
                            mode_next = MODE_IDLE;
                        else if (byte_in != CH_STAR)
                            mode_next = MODE_BLOCK;
                    end
                    default:
                    begin
                        starting = 1'b1;
                    end
                endcase
            end
        end

        // end of an open token or a pending slash
        if (closing)
        begin
            mode_next = MODE_IDLE;
            case (mode_reg)
                MODE_IDENT:
                begin
                    cls_valid = 1'b1;
                    cls_kind  = KIND_ID_END;
                end
                MODE_CONST:
                begin
                    cls_valid = 1'b1;
                    cls_kind  = (digit_reg && dots_reg <= 2'd1) ? KIND_CON_END
                                                                : KIND_BAD_CON;
                end
                MODE_SLASH:
                begin
                    cls_valid = 1'b1;
                    cls_kind  = KIND_PUNCT;
                    cls_char  = CH_SLASH;
                end
                default:
                begin
                    cls_valid = 1'b0;
                end
            endcase
        end

        // the byte opens a new token, is a separator, or is reported as a bad character
        if (starting)
        begin
            mode_next = MODE_IDLE;
            col_next  = col_inc;
            if (byte_in == CH_NEWLINE)
            begin
                line_next = (line_reg == POS_MAX) ? line_reg : line_reg + 1'b1;
                col_next  = '0;
            end
            else if (byte_in == CH_TAB)
            begin
                // next multiple of eight, minus one; cannot pass the all-ones max
                col_next = col_inc | POSITION_WIDTH'(TAB_MASK);
            end
            else if (byte_in == CH_SPACE || byte_in == CH_VTAB || byte_in == CH_FFEED)
            begin
                col_next = col_inc;
            end
            else if (byte_in == CH_SLASH)
            begin
                mode_next = MODE_SLASH;
            end
            else if (is_id_start(byte_in))
            begin
                mode_next = MODE_IDENT;
                len_next  = IDENT_LEN_W'(1);
                tok_valid = 1'b1;
                tok_kind  = KIND_ID_CHAR;
                tok_char  = byte_in;
            end
            else if (is_digit(byte_in) || byte_in == CH_DOT)
            begin
                mode_next  = MODE_CONST;
                dots_next  = (byte_in == CH_DOT) ? 2'd1 : 2'd0;
                digit_next = (byte_in != CH_DOT);
                tok_valid  = 1'b1;
                tok_kind   = KIND_CON_CHAR;
                tok_char   = byte_in;
            end
            else if (is_punct(byte_in))
            begin
                tok_valid = 1'b1;
                tok_kind  = KIND_PUNCT;
                tok_char  = byte_in;
            end
            else
            begin
                tok_valid = 1'b1;
                tok_kind  = KIND_BAD_CHAR;
            end
        end
    end

    // pack up to two results; the close result always goes first
    always_comb
    begin
        ent_b.kind      = tok_kind;
        ent_b.character = tok_char;
        ent_b.line      = line_reg;
        ent_b.column    = tok_col;
        ent_b.last      = 1'b1;
        if (cls_valid)
        begin
            ent_a.kind      = cls_kind;
            ent_a.character = cls_char;
            ent_a.line      = line_reg;
            ent_a.column    = col_reg;
            ent_a.last      = !tok_valid;
        end
        else
        begin
            ent_a = ent_b;
        end
        n_wr = 2'(cls_valid) + 2'(tok_valid);
    end

    assign wr_ptr_next = wr_ptr_reg + n_wr;
    assign rd_ptr_next = out_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + 3'(n_wr) - 3'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            len_reg    <= '0;
            dots_reg   <= '0;
            digit_reg  <= 1'b0;
            line_reg   <= '0;
            col_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            dots_reg   <= dots_next;
            digit_reg  <= digit_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0)
            queue_reg[wr_ptr_reg] <= ent_a;
        if (n_wr == 2'd2)
            queue_reg[wr_ptr_reg + 1'b1] <= ent_b;
    end

    assign kind      = queue_reg[rd_ptr_reg].kind;
    assign character = queue_reg[rd_ptr_reg].character;
    assign line      = queue_reg[rd_ptr_reg].line[15:0];
    assign column    = queue_reg[rd_ptr_reg].column[15:0];
    assign last      = queue_reg[rd_ptr_reg].last;

    // queue never holds more than its four entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    // queue occupancy tracks the pointer distance
    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[1:0] == 2'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers and count disagree");

    // end of input always leaves the lexer idle
    a_eof_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_input |=> mode_reg == MODE_IDLE)
        else $error("lexer not idle after end of input");

    // line counter never moves backward
    a_line_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 line_reg >= $past(line_reg))
        else $error("line counter went backward");

    // an identifier never grows past its length limit
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= IDENT_LEN_W'(MAX_IDENT_LEN))
        else $error("identifier length past limit");

endmodule

`default_nettype wire
